[rtl/srpc_pkg.sv]
`default_nettype none
package srpc_pkg;

	// Coil phase table and ramp timing table sizes
	localparam int PHASE_COUNT      = 40;
	localparam int PHASE_W          = 6;
	localparam int RAMP_ENTRIES     = 48;
	localparam int RAMP_IDX_W       = 6;
	localparam int RAMP_STEPS       = 48;
	localparam int SPAN_W           = $clog2(RAMP_STEPS + 1);
	localparam int HOME_PULSE_LIMIT = 5000;
	localparam int PULSE_W          = 13;

	localparam logic [PHASE_W-1:0]    PHASE_LAST = PHASE_W'(PHASE_COUNT - 1);
	localparam logic [RAMP_IDX_W-1:0] RAMP_LAST  = RAMP_IDX_W'(RAMP_ENTRIES - 1);
	localparam logic [SPAN_W-1:0]     SPAN_MAX   = SPAN_W'(RAMP_STEPS);

	// Mode codes, shared by the command field and the active_mode output
	localparam logic [2:0] MODE_OFF      = 3'd0;
	localparam logic [2:0] MODE_SINGLE   = 3'd1;
	localparam logic [2:0] MODE_DUAL     = 3'd2;
	localparam logic [2:0] MODE_SCAN     = 3'd3;
	localparam logic [2:0] MODE_HOME     = 3'd4;
	localparam logic [2:0] MODE_CAL_SCAN = 3'd5;

	// Configuration register map
	localparam int APB_ADDR_W = 5;
	localparam int REG_IDX_W  = 3;
	localparam logic [REG_IDX_W-1:0] REG_HOME_WAIT     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ESCAPE_TARGET = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ESCAPE_START  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_DUAL_READ     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_DUAL_DWELL    = 3'd4;

	typedef struct packed {
		logic [7:0]  home_wait_ticks;
		logic [14:0] home_escape_target;
		logic [14:0] home_escape_start;
		logic [15:0] dual_read_ticks;
		logic [15:0] dual_dwell_ticks;
	} cfg_t;

	typedef struct packed {
		logic        kind;
		logic [2:0]  mode;
		logic [15:0] target_step;
		logic [15:0] end_step;
		logic        home_sensor;
	} item_t;

	typedef struct packed {
		logic [15:0] coil_pattern;
		logic        coil_write;
		logic [15:0] position;
		logic [2:0]  active_mode;
		logic        home_found;
		logic        home_error;
		logic        readable;
		logic        new_target_reached;
	} result_t;

	// Home search stages
	typedef enum logic [2:0] {
		HS_START  = 3'b001,
		HS_ESCAPE = 3'b010,
		HS_SEARCH = 3'b100
	} home_stage_t;

	// Coil drive word for each phase; phase 0 and out-of-range indices give zero
	function automatic logic [15:0] coil_lookup(input logic [PHASE_W-1:0] idx);
		logic [15:0] w;
		unique case (idx)
			6'd0:  w = 16'h0000;  6'd1:  w = 16'h0004;  6'd2:  w = 16'h0006;
			6'd3:  w = 16'h000C;  6'd4:  w = 16'h0008;  6'd5:  w = 16'h0028;
			6'd6:  w = 16'h0038;  6'd7:  w = 16'h0068;  6'd8:  w = 16'h0048;
			6'd9:  w = 16'h0148;  6'd10: w = 16'h01C8;  6'd11: w = 16'h0348;
			6'd12: w = 16'h0248;  6'd13: w = 16'h0A48;  6'd14: w = 16'h0E48;
			6'd15: w = 16'h1A48;  6'd16: w = 16'h1248;  6'd17: w = 16'h5248;
			6'd18: w = 16'h7248;  6'd19: w = 16'hD248;  6'd20: w = 16'h9248;
			6'd21: w = 16'h924C;  6'd22: w = 16'h9246;  6'd23: w = 16'h9244;
			6'd24: w = 16'h9240;  6'd25: w = 16'h9260;  6'd26: w = 16'h9230;
			6'd27: w = 16'h9220;  6'd28: w = 16'h9200;  6'd29: w = 16'h9300;
			6'd30: w = 16'h9180;  6'd31: w = 16'h9100;  6'd32: w = 16'h9000;
			6'd33: w = 16'h9800;  6'd34: w = 16'h8C00;  6'd35: w = 16'h8800;
			6'd36: w = 16'h8000;  6'd37: w = 16'hC000;  6'd38: w = 16'h6000;
			6'd39: w = 16'h4000;
			default: w = 16'h0000;
		endcase
		return w;
	endfunction

	// Cumulative tick count at which each ramp step falls; past the end, the last entry
	function automatic logic [7:0] timing_lookup(input logic [RAMP_IDX_W-1:0] idx);
		logic [7:0] t;
		unique case (idx)
			6'd0:  t = 8'd5;   6'd1:  t = 8'd10;  6'd2:  t = 8'd15;  6'd3:  t = 8'd20;
			6'd4:  t = 8'd25;  6'd5:  t = 8'd30;  6'd6:  t = 8'd35;  6'd7:  t = 8'd40;
			6'd8:  t = 8'd45;  6'd9:  t = 8'd50;  6'd10: t = 8'd55;  6'd11: t = 8'd60;
			6'd12: t = 8'd65;  6'd13: t = 8'd70;  6'd14: t = 8'd75;  6'd15: t = 8'd80;
			6'd16: t = 8'd83;  6'd17: t = 8'd86;  6'd18: t = 8'd89;  6'd19: t = 8'd92;
			6'd20: t = 8'd95;  6'd21: t = 8'd98;  6'd22: t = 8'd101; 6'd23: t = 8'd104;
			6'd24: t = 8'd107; 6'd25: t = 8'd110; 6'd26: t = 8'd113; 6'd27: t = 8'd116;
			6'd28: t = 8'd119; 6'd29: t = 8'd122; 6'd30: t = 8'd125; 6'd31: t = 8'd128;
			6'd32: t = 8'd130; 6'd33: t = 8'd132; 6'd34: t = 8'd134; 6'd35: t = 8'd136;
			6'd36: t = 8'd138; 6'd37: t = 8'd140; 6'd38: t = 8'd142; 6'd39: t = 8'd144;
			6'd40: t = 8'd146; 6'd41: t = 8'd148; 6'd42: t = 8'd150; 6'd43: t = 8'd152;
			6'd44: t = 8'd154; 6'd45: t = 8'd156; 6'd46: t = 8'd158;
			default: t = 8'd160;
		endcase
		return t;
	endfunction

endpackage
`default_nettype wire

[rtl/srpc_cfg_regs.sv]
`default_nettype none
module srpc_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [srpc_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]                     pwdata,
	output logic      [31:0]                     prdata,
	output srpc_pkg::cfg_t                       cfg
);
	import srpc_pkg::*;

	cfg_t                 cfg_q;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] reg_idx;

	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;

	// Register writes on the access phase of a write transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.home_wait_ticks    <= 8'd10;
			cfg_q.home_escape_target <= 15'd1000;
			cfg_q.home_escape_start  <= 15'd900;
			cfg_q.dual_read_ticks    <= 16'd0;
			cfg_q.dual_dwell_ticks   <= 16'd0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_HOME_WAIT:     cfg_q.home_wait_ticks    <= pwdata[7:0];
				REG_ESCAPE_TARGET: cfg_q.home_escape_target <= pwdata[14:0];
				REG_ESCAPE_START:  cfg_q.home_escape_start  <= pwdata[14:0];
				REG_DUAL_READ:     cfg_q.dual_read_ticks    <= pwdata[15:0];
				REG_DUAL_DWELL:    cfg_q.dual_dwell_ticks   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read-back mux
	always_comb begin
		unique case (reg_idx)
			REG_HOME_WAIT:     prdata = 32'(cfg_q.home_wait_ticks);
			REG_ESCAPE_TARGET: prdata = 32'(cfg_q.home_escape_target);
			REG_ESCAPE_START:  prdata = 32'(cfg_q.home_escape_start);
			REG_DUAL_READ:     prdata = 32'(cfg_q.dual_read_ticks);
			REG_DUAL_DWELL:    prdata = 32'(cfg_q.dual_dwell_ticks);
			default:           prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

[rtl/srpc_core.sv]
`default_nettype none
module srpc_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  srpc_pkg::item_t        item,
	input  srpc_pkg::cfg_t         cfg,
	output srpc_pkg::result_t      result
);
	import srpc_pkg::*;

	// Motion state
	logic [PHASE_W-1:0]    phase_q, phase_n;
	logic [15:0]           pos_q, pos_n;
	logic [15:0]           dest_q, dest_n;
	logic [15:0]           prev_dest_q, prev_dest_n;
	logic [15:0]           accel_q, accel_n;
	logic [15:0]           decel_q, decel_n;
	logic [7:0]            rtick_q, rtick_n;
	logic [RAMP_IDX_W-1:0] ridx_q, ridx_n;
	logic [2:0]            mode_q, mode_n;
	home_stage_t           hstage_q, hstage_n;
	logic [7:0]            hwait_q, hwait_n;
	logic [PULSE_W-1:0]    hpulse_q, hpulse_n;
	logic [15:0]           dtick_q, dtick_n;
	logic                  dside_q, dside_n;
	logic [15:0]           dstart_q, dstart_n;
	logic [15:0]           dend_q, dend_n;
	logic                  found_q, found_n;
	logic                  error_q, error_n;
	logic                  read_q, read_n;

	logic step_en, step_fwd, reached;

	// Signed position compares
	logic dest_gt, dest_lt, acc_gt, acc_lt, dec_gt, dec_lt;
	assign dest_gt = $signed(dest_q)  > $signed(pos_q);
	assign dest_lt = $signed(dest_q)  < $signed(pos_q);
	assign acc_gt  = $signed(accel_q) > $signed(pos_q);
	assign acc_lt  = $signed(accel_q) < $signed(pos_q);
	assign dec_gt  = $signed(decel_q) > $signed(pos_q);
	assign dec_lt  = $signed(decel_q) < $signed(pos_q);

	logic       in_accel, in_cruise;
	logic [7:0] timing_cur, rtick_inc, hwait_inc;
	logic [15:0] dtick_inc;
	logic [PULSE_W:0] hpulse_inc;
	assign in_accel   = dest_gt ? acc_gt : acc_lt;
	assign in_cruise  = dest_gt ? dec_gt : dec_lt;
	assign timing_cur = timing_lookup(ridx_q);
	assign rtick_inc  = rtick_q + 8'd1;
	assign hwait_inc  = hwait_q + 8'd1;
	assign dtick_inc  = dtick_q + 16'd1;
	assign hpulse_inc = {1'b0, hpulse_q} + {{PULSE_W{1'b0}}, 1'b1};

	// Ramp planning for a single-move command: span is half the distance, capped
	logic        tgt_gt;
	logic [16:0] diff17, ndiff17, mid17;
	logic [15:0] mag, mid, span16;
	logic [SPAN_W-1:0] span;
	logic [15:0] plan_accel, plan_decel;
	assign tgt_gt     = $signed(item.target_step) > $signed(pos_q);
	assign diff17     = {item.target_step[15], item.target_step} - {pos_q[15], pos_q};
	assign ndiff17    = 17'd0 - diff17;
	assign mag        = tgt_gt ? diff17[15:0] : ndiff17[15:0];
	assign mid17      = {1'b0, mag} + 17'd1;
	assign mid        = mid17[16:1];
	assign span       = (mid > 16'(RAMP_STEPS)) ? SPAN_MAX : mid[SPAN_W-1:0];
	assign span16     = 16'(span);
	assign plan_accel = tgt_gt ? pos_q + span16 : pos_q - span16;
	assign plan_decel = tgt_gt ? item.target_step - span16 : item.target_step + span16;

	// Next-state logic for one item
	always_comb begin
		phase_n     = phase_q;
		pos_n       = pos_q;
		dest_n      = dest_q;
		prev_dest_n = prev_dest_q;
		accel_n     = accel_q;
		decel_n     = decel_q;
		rtick_n     = rtick_q;
		ridx_n      = ridx_q;
		mode_n      = mode_q;
		hstage_n    = hstage_q;
		hwait_n     = hwait_q;
		hpulse_n    = hpulse_q;
		dtick_n     = dtick_q;
		dside_n     = dside_q;
		dstart_n    = dstart_q;
		dend_n      = dend_q;
		found_n     = found_q;
		error_n     = error_q;
		read_n      = read_q;
		step_en     = 1'b0;
		step_fwd    = 1'b0;
		reached     = 1'b0;

		if (accept && item.kind) begin
			// Mode command: never steps
			unique case (item.mode)
				MODE_SINGLE: begin
					mode_n  = MODE_SINGLE;
					rtick_n = 8'd0;
					ridx_n  = '0;
					dest_n  = item.target_step;
					if (item.target_step != pos_q) begin
						accel_n = plan_accel;
						decel_n = plan_decel;
					end
				end
				MODE_DUAL: begin
					mode_n   = MODE_DUAL;
					dest_n   = item.target_step;
					dstart_n = item.target_step;
					dend_n   = item.end_step;
					read_n   = 1'b0;
					dtick_n  = 16'd0;
				end
				MODE_SCAN, MODE_CAL_SCAN: begin
					mode_n = item.mode;
					dest_n = item.target_step;
				end
				MODE_HOME: begin
					mode_n   = MODE_HOME;
					found_n  = 1'b0;
					error_n  = 1'b0;
					dest_n   = 16'd0;
					pos_n    = 16'd0;
					hstage_n = HS_START;
				end
				default: mode_n = MODE_OFF;
			endcase
		end else if (accept) begin
			// Timer tick
			unique case (mode_q)
				MODE_SINGLE: begin
					if (dest_gt || dest_lt) begin
						step_fwd = dest_gt;
						if (in_accel) begin
							rtick_n = rtick_inc;
							if (rtick_inc == timing_cur) begin
								step_en = 1'b1;
								if (ridx_q < RAMP_LAST) ridx_n = ridx_q + 1'b1;
							end
						end else if (in_cruise) begin
							ridx_n  = RAMP_LAST;
							step_en = 1'b1;
						end else begin
							rtick_n = rtick_q - 8'd1;
							if (rtick_q == timing_cur) begin
								step_en = 1'b1;
								if (ridx_q != '0) ridx_n = ridx_q - 1'b1;
							end
						end
					end else begin
						if (prev_dest_q != dest_q) begin
							prev_dest_n = dest_q;
							reached     = 1'b1;
						end
						mode_n = MODE_OFF;
					end
				end
				MODE_DUAL: begin
					dtick_n = dtick_inc;
					if (dest_q != pos_q) begin
						step_en  = 1'b1;
						step_fwd = dest_gt;
					end else begin
						if (dtick_inc >= cfg.dual_read_ticks) read_n = 1'b1;
						if (dtick_inc >= cfg.dual_dwell_ticks) begin
							read_n  = 1'b0;
							dest_n  = dside_q ? dstart_q : dend_q;
							dside_n = !dside_q;
							dtick_n = 16'd0;
						end
					end
				end
				MODE_SCAN, MODE_CAL_SCAN: begin
					step_en  = dest_gt || dest_lt;
					step_fwd = dest_gt;
				end
				MODE_HOME: begin
					unique case (hstage_q)
						HS_START: begin
							hpulse_n = '0;
							if (item.home_sensor) begin
								dest_n   = 16'(cfg.home_escape_target);
								pos_n    = 16'(cfg.home_escape_start);
								hstage_n = HS_ESCAPE;
							end else begin
								hstage_n = HS_SEARCH;
							end
						end
						HS_ESCAPE: begin
							if (dest_gt) begin
								hwait_n = hwait_inc;
								if (hwait_inc == cfg.home_wait_ticks) begin
									hwait_n  = 8'd0;
									step_en  = 1'b1;
									step_fwd = 1'b1;
								end
							end else begin
								hstage_n = HS_SEARCH;
							end
						end
						HS_SEARCH: begin
							hwait_n = hwait_inc;
							if (hwait_inc == cfg.home_wait_ticks) begin
								hwait_n = 8'd0;
								if (item.home_sensor) begin
									dest_n  = 16'd0;
									pos_n   = 16'd0;
									mode_n  = MODE_OFF;
									found_n = 1'b1;
								end else begin
									step_en = 1'b1;
								end
								// Pulse limit
								if (hpulse_inc > (PULSE_W+1)'(HOME_PULSE_LIMIT)) begin
									mode_n   = MODE_OFF;
									hpulse_n = '0;
									error_n  = 1'b1;
								end else begin
									hpulse_n = hpulse_inc[PULSE_W-1:0];
								end
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end

		// One step of the coil sequence and the position
		if (step_en) begin
			if (step_fwd) begin
				phase_n = (phase_q == PHASE_LAST) ? '0 : phase_q + 1'b1;
				pos_n   = pos_q + 16'd1;
			end else begin
				phase_n = (phase_q == '0) ? PHASE_LAST : phase_q - 1'b1;
				pos_n   = pos_q - 16'd1;
			end
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			pos_q       <= 16'd0;
			dest_q      <= 16'd0;
			prev_dest_q <= 16'd0;
			accel_q     <= 16'd0;
			decel_q     <= 16'd0;
			rtick_q     <= 8'd0;
			ridx_q      <= '0;
			mode_q      <= MODE_OFF;
			hstage_q    <= HS_START;
			hwait_q     <= 8'd0;
			hpulse_q    <= '0;
			dtick_q     <= 16'd0;
			dside_q     <= 1'b0;
			dstart_q    <= 16'd0;
			dend_q      <= 16'd0;
			found_q     <= 1'b0;
			error_q     <= 1'b0;
			read_q      <= 1'b0;
		end else if (accept) begin
			phase_q     <= phase_n;
			pos_q       <= pos_n;
			dest_q      <= dest_n;
			prev_dest_q <= prev_dest_n;
			accel_q     <= accel_n;
			decel_q     <= decel_n;
			rtick_q     <= rtick_n;
			ridx_q      <= ridx_n;
			mode_q      <= mode_n;
			hstage_q    <= hstage_n;
			hwait_q     <= hwait_n;
			hpulse_q    <= hpulse_n;
			dtick_q     <= dtick_n;
			dside_q     <= dside_n;
			dstart_q    <= dstart_n;
			dend_q      <= dend_n;
			found_q     <= found_n;
			error_q     <= error_n;
			read_q      <= read_n;
		end
	end

	// Result of this item, from the updated state
	always_comb begin
		result.coil_pattern       = coil_lookup(phase_n);
		result.coil_write         = step_en;
		result.position           = pos_n;
		result.active_mode        = mode_n;
		result.home_found         = found_n;
		result.home_error         = error_n;
		result.readable           = read_n;
		result.new_target_reached = reached;
	end

endmodule
`default_nettype wire

[rtl/stepper_ramp_position_controller.sv]
// Stepper ramp position controller.
// Input channel (item_valid/item_ready): each transfer is a timer tick (kind 0,
// with home_sensor sampled) or a mode command (kind 1, mode, target_step,
// end_step). Every item yields exactly one result on the result channel
// (result_valid/result_ready): coil drive word, step strobe, position,
// active mode, status flags and the new-target flag.
// Each result is loaded into the result register as its item is accepted.
// Throughput is one item per cycle without a stall; all state is updated
// by a single pass of logic from the motion registers to the result register.
// While the receiver stalls, the result register holds and item_ready is low;
// as soon as the result is taken a new item is accepted in the same cycle.
// Configuration is through the APB port (registers at 4*i, pready always
// high) and should only be written while no item is in flight.
// Reset (arst_n low) clears all motion state to position zero, mode off,
// flags clear, and loads the register defaults; no result is pending after it.
`default_nettype none
module stepper_ramp_position_controller (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration port
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [srpc_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]                     pwdata,
	output logic      [31:0]                     prdata,
	output logic                                 pready,
	// item channel
	input  wire logic                            item_valid,
	output logic                                 item_ready,
	input  wire logic                            kind,
	input  wire logic [2:0]                      mode,
	input  wire logic [15:0]                     target_step,
	input  wire logic [15:0]                     end_step,
	input  wire logic                            home_sensor,
	// result channel
	output logic                                 result_valid,
	input  wire logic                            result_ready,
	output logic [15:0]                          coil_pattern,
	output logic                                 coil_write,
	output logic [15:0]                          position,
	output logic [2:0]                           active_mode,
	output logic                                 home_found,
	output logic                                 home_error,
	output logic                                 readable,
	output logic                                 new_target_reached
);
	import srpc_pkg::*;

	cfg_t    cfg;
	item_t   item;
	result_t res_next;
	result_t res_q;
	logic    res_valid_q;
	logic    accept;

	assign pready = 1'b1;

	srpc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// Input transfer when the result slot is free or being emptied
	assign item_ready = !res_valid_q || result_ready;
	assign accept     = item_valid && item_ready;

	always_comb begin
		item.kind        = kind;
		item.mode        = mode;
		item.target_step = target_step;
		item.end_step    = end_step;
		item.home_sensor = home_sensor;
	end

	srpc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.cfg    (cfg),
		.result (res_next)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_next;
		end
	end

	assign result_valid       = res_valid_q;
	assign coil_pattern       = res_q.coil_pattern;
	assign coil_write         = res_q.coil_write;
	assign position           = res_q.position;
	assign active_mode        = res_q.active_mode;
	assign home_found         = res_q.home_found;
	assign home_error         = res_q.home_error;
	assign readable           = res_q.readable;
	assign new_target_reached = res_q.new_target_reached;

endmodule
`default_nettype wire

[rtl/srpc_checker.sv]
`default_nettype none
module srpc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        item_valid,
	input wire logic        item_ready,
	input wire logic        result_valid,
	input wire logic        result_ready,
	input wire logic [15:0] coil_pattern,
	input wire logic        coil_write,
	input wire logic [15:0] position,
	input wire logic [2:0]  active_mode,
	input wire logic        new_target_reached
);
	import srpc_pkg::*;

	// Every accepted item shows a result on the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> result_valid)
		else $error("no result after accepted item");

	// A stalled result blocks new items
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |-> !item_ready)
		else $error("item accepted while result stalled");

	// A reached target ends the move without a step
	a_reached_off: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && new_target_reached |-> active_mode == MODE_OFF && !coil_write)
		else $error("target reached with mode active or step taken");

	// Stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(position) && $stable(coil_pattern))
		else $error("stalled result changed");

endmodule

bind stepper_ramp_position_controller srpc_checker u_srpc_checker (.*);
`default_nettype wire

[verif/stepper_ramp_position_controller_test.sv]
module stepper_ramp_position_controller_test;
	timeunit 1ns;
	timeprecision 1ps;

	import srpc_pkg::*;

	localparam int CYCLE_LIMIT = 2_000_000;

	// Mode field values outside the defined set
	localparam logic [2:0] MODE_BAD_LO = 3'd6;
	localparam logic [2:0] MODE_BAD_HI = 3'd7;

	localparam logic [15:0] COIL_WORDS [PHASE_COUNT] = '{
		16'h0000, 16'h0004, 16'h0006, 16'h000C, 16'h0008, 16'h0028, 16'h0038, 16'h0068,
		16'h0048, 16'h0148, 16'h01C8, 16'h0348, 16'h0248, 16'h0A48, 16'h0E48, 16'h1A48,
		16'h1248, 16'h5248, 16'h7248, 16'hD248, 16'h9248, 16'h924C, 16'h9246, 16'h9244,
		16'h9240, 16'h9260, 16'h9230, 16'h9220, 16'h9200, 16'h9300, 16'h9180, 16'h9100,
		16'h9000, 16'h9800, 16'h8C00, 16'h8800, 16'h8000, 16'hC000, 16'h6000, 16'h4000};

	localparam logic [7:0] RAMP_TIMES [RAMP_ENTRIES] = '{
		8'd5,   8'd10,  8'd15,  8'd20,  8'd25,  8'd30,  8'd35,  8'd40,
		8'd45,  8'd50,  8'd55,  8'd60,  8'd65,  8'd70,  8'd75,  8'd80,
		8'd83,  8'd86,  8'd89,  8'd92,  8'd95,  8'd98,  8'd101, 8'd104,
		8'd107, 8'd110, 8'd113, 8'd116, 8'd119, 8'd122, 8'd125, 8'd128,
		8'd130, 8'd132, 8'd134, 8'd136, 8'd138, 8'd140, 8'd142, 8'd144,
		8'd146, 8'd148, 8'd150, 8'd152, 8'd154, 8'd156, 8'd158, 8'd160};

	// DUT connections
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic item_valid = 1'b0;
	logic item_ready;
	logic kind = 1'b0;
	logic [2:0] mode = MODE_OFF;
	logic [15:0] target_step = '0;
	logic [15:0] end_step = '0;
	logic home_sensor = 1'b0;
	logic result_valid;
	logic result_ready = 1'b1;
	logic [15:0] coil_pattern;
	logic coil_write;
	logic [15:0] position;
	logic [2:0] active_mode;
	logic home_found;
	logic home_error;
	logic readable;
	logic new_target_reached;

	stepper_ramp_position_controller i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.item_valid(item_valid), .item_ready(item_ready),
		.kind(kind), .mode(mode), .target_step(target_step), .end_step(end_step),
		.home_sensor(home_sensor),
		.result_valid(result_valid), .result_ready(result_ready),
		.coil_pattern(coil_pattern), .coil_write(coil_write), .position(position),
		.active_mode(active_mode), .home_found(home_found), .home_error(home_error),
		.readable(readable), .new_target_reached(new_target_reached)
	);

	// Motion model state, starting from the reset values
	cfg_t cfg_model = '{home_wait_ticks: 8'd10, home_escape_target: 15'd1000,
		home_escape_start: 15'd900, dual_read_ticks: 16'd0, dual_dwell_ticks: 16'd0};
	logic [PHASE_W-1:0]    ph_idx = '0;
	logic signed [15:0]    pos = '0;
	logic signed [15:0]    dest = '0;
	logic signed [15:0]    prev_dest = '0;
	logic signed [15:0]    accel_end = '0;
	logic signed [15:0]    decel_start = '0;
	logic [7:0]            ramp_cnt = '0;
	logic [RAMP_IDX_W-1:0] ramp_idx = '0;
	logic [2:0]            mode_q = MODE_OFF;
	home_stage_t           hstage = HS_START;
	logic [7:0]            hwait = '0;
	logic [PULSE_W-1:0]    hpulse = '0;
	logic [15:0]           dual_cnt = '0;
	logic                  dual_side = 1'b0;
	logic [15:0]           dual_a = '0;
	logic [15:0]           dual_b = '0;
	logic                  flag_found = 1'b0;
	logic                  flag_error = 1'b0;
	logic                  flag_read = 1'b0;
	logic                  stepped_now = 1'b0;

	result_t expected_results [$];
	int mismatch_count = 0;
	int counted_items = 0;
	int cycle_count = 0;
	int ready_hold = 0;
	bit idle_on = 1'b0;
	result_t exp_res, got_res;

	// Clock
	initial begin
		forever #2 clk = ~clk;
	end

	// One step of the motor, with phase wrap at the table ends
	function automatic void take_step(input logic fwd);
		if (fwd) begin
			ph_idx = (ph_idx < PHASE_LAST) ? ph_idx + 6'd1 : '0;
			pos = pos + 16'sd1;
		end else begin
			ph_idx = (ph_idx != '0) ? ph_idx - 6'd1 : PHASE_LAST;
			pos = pos - 16'sd1;
		end
		stepped_now = 1'b1;
	endfunction

	function automatic void step_toward();
		if (dest > pos)
			take_step(1'b1);
		else if (dest < pos)
			take_step(1'b0);
	endfunction

	function automatic logic [7:0] ramp_time(input logic [RAMP_IDX_W-1:0] idx);
		return RAMP_TIMES[(idx < RAMP_ENTRIES) ? idx : RAMP_LAST];
	endfunction

	// Advance the motion model by one item and form its result
	task automatic predict_motion(input item_t it, output result_t res);
		logic fwd = 1'b0;
		logic moving = 1'b0;
		logic in_accel = 1'b0;
		logic in_cruise = 1'b0;
		logic reached = 1'b0;
		logic [7:0] old_cnt;
		int mid, span, next_pulse;
		stepped_now = 1'b0;
		if (it.kind) begin
			mode_q = (it.mode <= MODE_CAL_SCAN) ? it.mode : MODE_OFF;
			case (mode_q)
				MODE_SINGLE: begin
					// plan the trapezoid; a zero-length move keeps the old ramp points
					ramp_cnt = '0;
					ramp_idx = '0;
					dest = it.target_step;
					if (dest > pos) begin
						mid = (int'(dest) + 1 - int'(pos)) / 2;
						span = (mid > RAMP_STEPS) ? RAMP_STEPS : mid;
						accel_end = pos + 16'(span);
						decel_start = dest - 16'(span);
					end else if (dest < pos) begin
						mid = (int'(pos) + 1 - int'(dest)) / 2;
						span = (mid > RAMP_STEPS) ? RAMP_STEPS : mid;
						accel_end = pos - 16'(span);
						decel_start = dest + 16'(span);
					end
				end
				MODE_DUAL: begin
					dest = it.target_step;
					dual_a = it.target_step;
					dual_b = it.end_step;
					flag_read = 1'b0;
					dual_cnt = '0;
				end
				MODE_SCAN, MODE_CAL_SCAN: dest = it.target_step;
				MODE_HOME: begin
					flag_found = 1'b0;
					flag_error = 1'b0;
					dest = '0;
					pos = '0;
					hstage = HS_START;
				end
				default: ;
			endcase
		end else begin
			case (mode_q)
				MODE_SINGLE: begin
					moving = 1'b1;
					if (dest > pos) begin
						fwd = 1'b1;
						in_accel = accel_end > pos;
						in_cruise = decel_start > pos;
					end else if (dest < pos) begin
						fwd = 1'b0;
						in_accel = accel_end < pos;
						in_cruise = decel_start < pos;
					end else begin
						moving = 1'b0;
						if (prev_dest != dest) begin
							prev_dest = dest;
							reached = 1'b1;
						end
						mode_q = MODE_OFF;
					end
					if (moving) begin
						if (in_accel) begin
							ramp_cnt = ramp_cnt + 8'd1;
							if (ramp_cnt == ramp_time(ramp_idx)) begin
								take_step(fwd);
								if (ramp_idx < RAMP_LAST)
									ramp_idx = ramp_idx + 6'd1;
							end
						end else if (in_cruise) begin
							ramp_idx = RAMP_LAST;
							take_step(fwd);
						end else begin
							old_cnt = ramp_cnt;
							ramp_cnt = ramp_cnt - 8'd1;
							if (old_cnt == ramp_time(ramp_idx)) begin
								take_step(fwd);
								if (ramp_idx != '0)
									ramp_idx = ramp_idx - 6'd1;
							end
						end
					end
				end
				MODE_DUAL: begin
					dual_cnt = dual_cnt + 16'd1;
					if (dest != pos) begin
						step_toward();
					end else begin
						if (dual_cnt >= cfg_model.dual_read_ticks)
							flag_read = 1'b1;
						if (dual_cnt >= cfg_model.dual_dwell_ticks) begin
							flag_read = 1'b0;
							if (!dual_side) begin
								dest = dual_b;
								dual_side = 1'b1;
							end else begin
								dest = dual_a;
								dual_side = 1'b0;
							end
							dual_cnt = '0;
						end
					end
				end
				MODE_SCAN, MODE_CAL_SCAN: step_toward();
				MODE_HOME: begin
					case (hstage)
						HS_START: begin
							hpulse = '0;
							if (it.home_sensor) begin
								dest = {1'b0, cfg_model.home_escape_target};
								pos = {1'b0, cfg_model.home_escape_start};
								hstage = HS_ESCAPE;
							end else begin
								hstage = HS_SEARCH;
							end
						end
						HS_ESCAPE: begin
							// already past the escape target: go straight to the search
							if (dest > pos) begin
								hwait = hwait + 8'd1;
								if (hwait == cfg_model.home_wait_ticks) begin
									hwait = '0;
									take_step(1'b1);
								end
							end else begin
								hstage = HS_SEARCH;
							end
						end
						HS_SEARCH: begin
							hwait = hwait + 8'd1;
							if (hwait == cfg_model.home_wait_ticks) begin
								hwait = '0;
								if (it.home_sensor) begin
									dest = '0;
									pos = '0;
									mode_q = MODE_OFF;
									flag_found = 1'b1;
								end else begin
									take_step(1'b0);
								end
								next_pulse = int'(hpulse) + 1;
								if (next_pulse > HOME_PULSE_LIMIT) begin
									mode_q = MODE_OFF;
									hpulse = '0;
									flag_error = 1'b1;
								end else begin
									hpulse = PULSE_W'(next_pulse);
								end
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
		res.coil_pattern = (ph_idx < PHASE_COUNT) ? COIL_WORDS[ph_idx] : 16'h0000;
		res.coil_write = stepped_now;
		res.position = pos;
		res.active_mode = mode_q;
		res.home_found = flag_found;
		res.home_error = flag_error;
		res.readable = flag_read;
		res.new_target_reached = reached;
	endtask

	function automatic string fmt_result(input result_t r);
		return $sformatf("pattern %h write %b pos %0d mode %0d found %b error %b read %b new %b",
			r.coil_pattern, r.coil_write, $signed(r.position), r.active_mode,
			r.home_found, r.home_error, r.readable, r.new_target_reached);
	endfunction

	function automatic item_t tick_item(input logic sensor);
		item_t it;
		it.kind = 1'b0;
		it.mode = 3'($urandom);
		it.target_step = 16'($urandom);
		it.end_step = 16'($urandom);
		it.home_sensor = sensor;
		return it;
	endfunction

	function automatic item_t cmd_item(input logic [2:0] m, input logic [15:0] t,
		input logic [15:0] e);
		item_t it;
		it.kind = 1'b1;
		it.mode = m;
		it.target_step = t;
		it.end_step = e;
		it.home_sensor = 1'($urandom);
		return it;
	endfunction

	// Offer one item, optionally after an idle burst, and log its expected result
	task automatic send_item(input item_t it);
		result_t res;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		item_valid <= 1'b1;
		kind <= it.kind;
		mode <= it.mode;
		target_step <= it.target_step;
		end_step <= it.end_step;
		home_sensor <= it.home_sensor;
		do @(posedge clk); while (!item_ready);
		// ticks while the motor is off do nothing
		if (it.kind || mode_q != MODE_OFF)
			counted_items++;
		predict_motion(it, res);
		expected_results.push_back(res);
	endtask

	// Drain all outstanding results
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_HOME_WAIT:     cfg_model.home_wait_ticks = val[7:0];
			REG_ESCAPE_TARGET: cfg_model.home_escape_target = val[14:0];
			REG_ESCAPE_START:  cfg_model.home_escape_start = val[14:0];
			REG_DUAL_READ:     cfg_model.dual_read_ticks = val[15:0];
			REG_DUAL_DWELL:    cfg_model.dual_dwell_ticks = val[15:0];
			default: ;
		endcase
	endtask

	// Write the whole register set once the block is idle
	task automatic set_config(input cfg_t c);
		wait_idle();
		write_reg(REG_HOME_WAIT, 32'(c.home_wait_ticks));
		write_reg(REG_ESCAPE_TARGET, 32'(c.home_escape_target));
		write_reg(REG_ESCAPE_START, 32'(c.home_escape_start));
		write_reg(REG_DUAL_READ, 32'(c.dual_read_ticks));
		write_reg(REG_DUAL_DWELL, 32'(c.dual_dwell_ticks));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly well-formed command plus tick sequences, some noise
	task automatic run_random_phase(input int n_items);
		int goal, r, n, delta;
		logic [15:0] t, e;
		logic [2:0] m;
		item_t it;
		goal = counted_items + n_items;
		while (counted_items < goal) begin
			r = $urandom_range(0, 19);
			if (r <= 6) begin
				// single move, usually run to completion
				r = $urandom_range(0, 99);
				if (r < 10)
					delta = 0;
				else if (r < 70)
					delta = $urandom_range(1, 4);
				else if (r < 92)
					delta = $urandom_range(5, 40);
				else
					delta = $urandom_range(96, 110);
				if ($urandom_range(0, 1))
					delta = -delta;
				t = 16'(int'(pos) + delta);
				if (r >= 96)
					t = 16'($urandom);
				send_item(cmd_item(MODE_SINGLE, t, 16'($urandom)));
				if (r >= 96) begin
					repeat ($urandom_range(5, 40)) send_item(tick_item(1'($urandom)));
				end else if ($urandom_range(0, 7) == 0) begin
					repeat ($urandom_range(1, 30)) send_item(tick_item(1'($urandom)));
				end else begin
					n = 0;
					while (mode_q == MODE_SINGLE && n < 1200) begin
						send_item(tick_item(1'($urandom)));
						n++;
					end
					repeat ($urandom_range(0, 2)) send_item(tick_item(1'($urandom)));
				end
			end else if (r <= 9) begin
				// dual positions near the current one
				t = 16'(int'(pos) + int'($urandom_range(0, 8)) - 4);
				e = 16'(int'(pos) + int'($urandom_range(0, 12)) - 6);
				send_item(cmd_item(MODE_DUAL, t, e));
				repeat ($urandom_range(10, 60)) send_item(tick_item(1'($urandom)));
			end else if (r <= 12) begin
				m = $urandom_range(0, 1) ? MODE_SCAN : MODE_CAL_SCAN;
				t = 16'(int'(pos) + int'($urandom_range(0, 50)) - 25);
				if ($urandom_range(0, 7) == 0)
					t = 16'($urandom);
				send_item(cmd_item(m, t, 16'($urandom)));
				repeat ($urandom_range(3, 40)) send_item(tick_item(1'($urandom)));
			end else if (r <= 15) begin
				// home search with a sparse sensor
				send_item(cmd_item(MODE_HOME, 16'($urandom), 16'($urandom)));
				send_item(tick_item(1'($urandom)));
				repeat ($urandom_range(20, 120))
					send_item(tick_item($urandom_range(0, 9) == 0));
			end else if (r <= 17) begin
				repeat ($urandom_range(1, 8)) begin
					it.kind = 1'($urandom);
					it.mode = 3'($urandom);
					it.target_step = 16'($urandom);
					it.end_step = 16'($urandom);
					it.home_sensor = 1'($urandom);
					send_item(it);
				end
			end else begin
				m = (r == 18) ? 3'($urandom_range(MODE_BAD_LO, MODE_BAD_HI)) : MODE_OFF;
				send_item(cmd_item(m, 16'($urandom), 16'($urandom)));
				repeat ($urandom_range(1, 5)) send_item(tick_item(1'($urandom)));
			end
		end
	endtask

	task automatic test_directed_fields();
		send_item(tick_item(1'b1));
		send_item(cmd_item(MODE_BAD_HI, 16'h7FFF, 16'h8000));
		send_item(cmd_item(MODE_BAD_LO, 16'h8000, 16'h7FFF));
		// one-step move: steps on the fifth tick, flags arrival on the sixth
		send_item(cmd_item(MODE_SINGLE, 16'h0001, 16'h0000));
		repeat (6) send_item(tick_item(1'b0));
		// target already reached: old ramp points stay, no new-target flag
		send_item(cmd_item(MODE_SINGLE, 16'h0001, 16'hFFFF));
		send_item(tick_item(1'b0));
		send_item(cmd_item(MODE_SINGLE, 16'hFFFF, 16'h0000));
		send_item(tick_item(1'b1));
		send_item(cmd_item(MODE_SCAN, 16'h7FFF, 16'h0000));
		send_item(tick_item(1'b1));
		send_item(cmd_item(MODE_CAL_SCAN, 16'h8000, 16'hFFFF));
		send_item(tick_item(1'b0));
		send_item(cmd_item(MODE_DUAL, 16'h7FFF, 16'h8000));
		send_item(tick_item(1'b0));
		send_item(cmd_item(MODE_HOME, 16'hFFFF, 16'hFFFF));
		send_item(tick_item(1'b1));
		send_item(tick_item(1'b0));
		send_item(cmd_item(MODE_OFF, 16'h8000, 16'h8000));
		send_item(tick_item(1'b1));
	endtask

	// Zero wait: the 8-bit wait counter wraps, one step per 256 ticks
	task automatic test_home_wait_zero();
		set_config('{home_wait_ticks: 8'd0, home_escape_target: 15'd1000,
			home_escape_start: 15'd900, dual_read_ticks: 16'd0, dual_dwell_ticks: 16'd0});
		send_item(cmd_item(MODE_HOME, 16'h0000, 16'h0000));
		repeat (259) send_item(tick_item(1'b0));
	endtask

	task automatic test_random_settings();
		cfg_t c;
		set_config('{home_wait_ticks: 8'd2, home_escape_target: 15'd20,
			home_escape_start: 15'd10, dual_read_ticks: 16'd3, dual_dwell_ticks: 16'd8});
		run_random_phase(50);
		set_config('{home_wait_ticks: 8'd255, home_escape_target: 15'h7FFF,
			home_escape_start: 15'h7FFF, dual_read_ticks: 16'hFFFF, dual_dwell_ticks: 16'hFFFF});
		run_random_phase(40);
		// escape start beyond its target
		set_config('{home_wait_ticks: 8'd1, home_escape_target: 15'd0,
			home_escape_start: 15'h7FFF, dual_read_ticks: 16'd0, dual_dwell_ticks: 16'd0});
		run_random_phase(50);
		c.home_wait_ticks = 8'($urandom_range(1, 8));
		c.home_escape_target = 15'($urandom_range(0, 40));
		c.home_escape_start = 15'($urandom_range(0, 40));
		c.dual_read_ticks = 16'($urandom_range(0, 10));
		c.dual_dwell_ticks = 16'($urandom_range(0, 12));
		set_config(c);
		run_random_phase(50);
	endtask

	// Closing stretch with both sides always ready
	task automatic test_no_idle_tail();
		cfg_t c;
		c.home_wait_ticks = 8'($urandom_range(1, 4));
		c.home_escape_target = 15'($urandom_range(0, 30));
		c.home_escape_start = 15'($urandom_range(0, 30));
		c.dual_read_ticks = 16'($urandom_range(0, 6));
		c.dual_dwell_ticks = 16'($urandom_range(0, 8));
		set_config(c);
		idle_on = 1'b0;
		run_random_phase(60);
	endtask

	// Result side stalls in random bursts
	always @(posedge clk) begin
		if (!idle_on) begin
			result_ready <= 1'b1;
			ready_hold = 0;
		end else if (ready_hold > 0) begin
			ready_hold--;
		end else if ($urandom_range(0, 2) == 0) begin
			result_ready <= 1'b0;
			ready_hold = $urandom_range(0, 16);
		end else begin
			result_ready <= 1'b1;
			ready_hold = $urandom_range(0, 39);
		end
	end

	// Check each result transfer against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			got_res.coil_pattern = coil_pattern;
			got_res.coil_write = coil_write;
			got_res.position = position;
			got_res.active_mode = active_mode;
			got_res.home_found = home_found;
			got_res.home_error = home_error;
			got_res.readable = readable;
			got_res.new_target_reached = new_target_reached;
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: %s", fmt_result(got_res));
			end else begin
				exp_res = expected_results.pop_front();
				if (got_res !== exp_res) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected %s, got %s",
							fmt_result(exp_res), fmt_result(got_res));
				end
			end
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_on = 1'b1;
		test_directed_fields();
		test_home_wait_zero();
		test_random_settings();
		test_no_idle_tail();
		wait_idle();
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[filelist.f]
rtl/srpc_pkg.sv
rtl/srpc_cfg_regs.sv
rtl/srpc_core.sv
rtl/stepper_ramp_position_controller.sv
rtl/srpc_checker.sv
verif/stepper_ramp_position_controller_test.sv
